// ===== design/gbw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbw_pkg
// Shared types and constants for the breadth-first graph walk block.
// ----------------------------------------------------------------------------
package gbw_pkg;

  // Field widths
  localparam int unsigned NODE_W    = 6;   // node index
  localparam int unsigned ROW_W     = 64;  // adjacency row on the input port
  localparam int unsigned COUNT_W   = 7;   // node_count register
  localparam int unsigned NODES_DEF = 64;  // default graph size

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 7'd64;

  // Input item kind
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_START = 1'b1
  } kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_row;    // store the incoming adjacency row
    logic start_walk;  // seed queue with node 0, set visited map to node 0 only
    logic read_queue;  // dequeue the head entry into the current node
    logic read_row;    // fetch the current node's adjacency row
    logic enqueue;     // push the lowest new neighbor
    logic emit;        // load the output register with the current node
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cand_any;     // unvisited neighbors remain for the current node
    logic out_free;     // output register can take an item this cycle
    logic queue_empty;  // head has caught up with tail
  } sts_t;

endpackage

// ===== design/gbw_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbw_in_if / gbw_out_if
// Valid/ready channels for walk commands and visited-node results.
// ----------------------------------------------------------------------------
interface gbw_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [gbw_pkg::NODE_W-1:0]       row_index;
  logic [gbw_pkg::ROW_W-1:0]        row_bits;

  modport source (output valid, kind, row_index, row_bits, input ready);
  modport sink   (input valid, kind, row_index, row_bits, output ready);
endinterface

interface gbw_out_if;
  logic                             valid;
  logic                             ready;
  logic [gbw_pkg::NODE_W-1:0]       visited_node;
  logic                             last;

  modport source (output valid, visited_node, last, input ready);
  modport sink   (input valid, visited_node, last, output ready);
endinterface

// ===== design/graph_breadth_first_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_breadth_first_walk
// Row load item: accepted while idle, ready again on the next cycle.
// Start item: per reached node the steps dequeue, row read, scan and emit run
// in order, with one scan step per neighbor enqueued and a final scan step when
// none are left; emit waits while the output is stalled; no new item during a walk.
// Reset is asynchronous and active low: idle, node_count = 64, visited map
// and queue pointers cleared; stored rows and queue entries are not cleared.
// ----------------------------------------------------------------------------
module graph_breadth_first_walk #(
  parameter int unsigned NODES = gbw_pkg::NODES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gbw_pkg::COUNT_W-1:0] cfg_wdata_i,
  gbw_in_if.sink                      in_i,
  gbw_out_if.source                   out_o
);

  gbw_pkg::cmd_t cmd;
  gbw_pkg::sts_t sts;

  // Sequencer
  gbw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and walk datapath
  gbw_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .row_index_i    (in_i.row_index),
    .row_bits_i     (in_i.row_bits),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .visited_node_o (out_o.visited_node),
    .last_o         (out_o.last)
  );

endmodule

// ===== design/gbw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbw_ctrl
// Sequencer for the walk: dequeue, row fetch, neighbor scan, result emit.
// ----------------------------------------------------------------------------
module gbw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_kind_i,
  output logic          in_ready_o,
  input  gbw_pkg::sts_t sts_i,
  output gbw_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RDQ   = 5'b00010,
    S_RDROW = 5'b00100,
    S_SCAN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (gbw_pkg::kind_e'(in_kind_i) == gbw_pkg::KIND_START) begin
            cmd_o.start_walk = 1'b1;
            state_d          = S_RDQ;
          end else begin
            cmd_o.load_row = 1'b1;
          end
        end
      end
      S_RDQ: begin
        cmd_o.read_queue = 1'b1;
        state_d          = S_RDROW;
      end
      S_RDROW: begin
        cmd_o.read_row = 1'b1;
        state_d        = S_SCAN;
      end
      S_SCAN: begin
        // one new neighbor per cycle until none are left
        if (sts_i.cand_any) begin
          cmd_o.enqueue = 1'b1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.queue_empty ? S_IDLE : S_RDQ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/gbw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbw_dp
// Adjacency store, node queue, visited map, neighbor picker, output register.
// ----------------------------------------------------------------------------
module gbw_dp #(
  parameter int unsigned NODES = gbw_pkg::NODES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbw_pkg::cmd_t                 cmd_i,
  output gbw_pkg::sts_t                 sts_o,
  input  logic                          cfg_we_i,
  input  logic [gbw_pkg::COUNT_W-1:0]   cfg_wdata_i,
  input  logic [gbw_pkg::NODE_W-1:0]    row_index_i,
  input  logic [gbw_pkg::ROW_W-1:0]     row_bits_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [gbw_pkg::NODE_W-1:0]    visited_node_o,
  output logic                          last_o
);

  localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CW = $clog2(NODES + 1);

  // Lowest set bit: pick the group of eight, then the bit inside it
  function automatic logic [gbw_pkg::NODE_W-1:0] first_set(input logic [63:0] v);
    logic [2:0] grp;
    logic [2:0] bitp;
    logic [7:0] sel;
    grp = '0;
    for (int g = 7; g >= 0; g--) begin
      if (|v[g*8 +: 8]) grp = 3'(g);
    end
    sel  = v[{grp, 3'b000} +: 8];
    bitp = '0;
    for (int b = 7; b >= 0; b--) begin
      if (sel[b]) bitp = 3'(b);
    end
    return {grp, bitp};
  endfunction

  logic [NODES-1:0]                 adj_mem [NODES];
  logic [gbw_pkg::NODE_W-1:0]       q_mem   [NODES];

  logic [gbw_pkg::COUNT_W-1:0]      node_count_q;
  logic [CW-1:0]                    head_q, tail_q;
  logic [NODES-1:0]                 visited_q, nmask_q, row_q;
  logic [gbw_pkg::NODE_W-1:0]       cur_q;
  logic                             out_valid_q, out_last_q;
  logic [gbw_pkg::NODE_W-1:0]       out_node_q;

  logic [gbw_pkg::COUNT_W-1:0]      n_use;
  logic [NODES-1:0]                 nmask_d, cand, pick_oh;
  logic [gbw_pkg::NODE_W-1:0]       pick;
  logic                             row_in_range;
  logic                             q_we;
  logic [AW-1:0]                    q_waddr;
  logic [gbw_pkg::NODE_W-1:0]       q_wdata;

  // Node count clamped to 1..NODES, turned into a bit mask
  always_comb begin
    n_use = node_count_q;
    if (node_count_q == '0) begin
      n_use = gbw_pkg::COUNT_W'(1);
    end else if (node_count_q > gbw_pkg::COUNT_W'(NODES)) begin
      n_use = gbw_pkg::COUNT_W'(NODES);
    end
    for (int j = 0; j < NODES; j++) begin
      nmask_d[j] = (gbw_pkg::COUNT_W'(j) < n_use);
    end
  end

  // Unvisited neighbors of the current node, lowest first
  assign cand    = row_q & ~visited_q & nmask_q;
  assign pick    = first_set(64'(cand));
  assign pick_oh = NODES'(1) << pick;

  assign row_in_range = ({1'b0, row_index_i} < gbw_pkg::COUNT_W'(NODES));

  assign sts_o.cand_any    = |cand;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.queue_empty = (head_q == tail_q);

  // Queue write port: seed at start, neighbors while scanning
  assign q_we    = cmd_i.start_walk || cmd_i.enqueue;
  assign q_waddr = cmd_i.start_walk ? '0 : tail_q[AW-1:0];
  assign q_wdata = cmd_i.start_walk ? '0 : pick;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= gbw_pkg::NODE_COUNT_RST;
      head_q       <= '0;
      tail_q       <= '0;
      visited_q    <= '0;
      nmask_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (cmd_i.start_walk) begin
        visited_q <= NODES'(1);
        nmask_q   <= nmask_d;
        head_q    <= '0;
        tail_q    <= CW'(1);
      end
      if (cmd_i.read_queue) begin
        head_q <= head_q + CW'(1);
      end
      if (cmd_i.enqueue) begin
        visited_q <= visited_q | pick_oh;
        tail_q    <= tail_q + CW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Adjacency memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row && row_in_range) begin
      adj_mem[row_index_i[AW-1:0]] <= row_bits_i[NODES-1:0];
    end
    if (cmd_i.read_row) begin
      row_q <= adj_mem[cur_q[AW-1:0]];
    end
  end

  // Queue memory
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (cmd_i.read_queue) begin
      cur_q <= q_mem[head_q[AW-1:0]];
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_node_q <= cur_q;
      out_last_q <= (head_q == tail_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign visited_node_o = out_node_q;
  assign last_o         = out_last_q;

endmodule

// ===== design/gbw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbw_checker
// Port-level checks of the walk block's sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module gbw_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_kind_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [gbw_pkg::NODE_W-1:0] out_node_i,
  input logic                       out_last_i
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_node_i) && $stable(out_last_i)))
    else $error("gbw: stalled result changed");

  // A start item makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_kind_i == gbw_pkg::KIND_START) |=> !in_ready_i)
    else $error("gbw: ready right after a start item");

  // A row load leaves the block ready
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_kind_i == gbw_pkg::KIND_LOAD) |=> in_ready_i)
    else $error("gbw: not ready after a row load");

  // While a non-final node waits, the walk is still running
  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_last_i) |-> !in_ready_i)
    else $error("gbw: idle before the final node");

endmodule

bind graph_breadth_first_walk gbw_checker u_gbw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_node_i  (out_o.visited_node),
  .out_last_i  (out_o.last)
);
